// ===== rtl/skad_pkg.sv =====
// Shared types, constants and helpers for the scalar Kalman anomaly detector.
// Used by skad_cfg_regs, skad_gain_unit and scalar_kalman_anomaly_detector.
package skad_pkg;

  // Field widths of the sample and result channels.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DEV_W    = 17;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned TIME_W   = 40;
  localparam int unsigned TAG_W    = 16;

  // Variance format: unsigned Q4.28.
  localparam int unsigned VAR_INT_BITS  = 4;
  localparam int unsigned VAR_FRAC_BITS = 28;
  localparam int unsigned VAR_W         = VAR_INT_BITS + VAR_FRAC_BITS;
  localparam logic [VAR_W-1:0] VAR_ONE  = VAR_W'(1) << VAR_FRAC_BITS;

  // Default number of fraction bits of the filter gain.
  localparam int unsigned GAIN_FRAC_BITS = 16;

  // Configuration registers.
  localparam int unsigned THR_W      = 16;
  localparam int unsigned NOISE_W    = 29;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 29;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1638);
  localparam logic [NOISE_W-1:0] QNOISE_RESET = NOISE_W'(134218);
  localparam logic [NOISE_W-1:0] RNOISE_RESET = NOISE_W'(671089);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_PROC_NOISE = 2'd1,
    CFG_MEAS_NOISE = 2'd2
  } skad_cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [NOISE_W-1:0] proc_noise;
    logic [NOISE_W-1:0] meas_noise;
  } skad_cfg_t;

  // Status of the serial gain unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } skad_gain_stat_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_START,
    ST_WAIT,
    ST_UPDATE
  } skad_state_e;

  // Gain unit states.
  typedef enum logic [1:0] {
    G_IDLE,
    G_DEN,
    G_RUN
  } skad_gain_state_e;

  // How the quotient bits of the gain are produced.
  typedef enum logic [1:0] {
    GM_DIV,
    GM_ZERO,
    GM_FULL
  } skad_gain_mode_e;

  // Variance plus noise, saturated to the largest variance value.
  function automatic logic [VAR_W-1:0] sat_add(input logic [VAR_W-1:0]   a,
                                               input logic [NOISE_W-1:0] b);
    logic [VAR_W:0] s;
    s = {1'b0, a} + (VAR_W+1)'(b);
    sat_add = s[VAR_W] ? {VAR_W{1'b1}} : s[VAR_W-1:0];
  endfunction

endpackage

// ===== rtl/skad_cfg_regs.sv =====
// Configuration register bank of the anomaly detector: threshold and noise terms.
// Depends on skad_pkg for widths, reset values and register indexes.
module skad_cfg_regs
  import skad_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output skad_cfg_t             cfg_o
);

  logic [THR_W-1:0]   thr_q, thr_d;
  logic [NOISE_W-1:0] qn_q, qn_d;
  logic [NOISE_W-1:0] rn_q, rn_d;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    thr_d = thr_q;
    qn_d  = qn_q;
    rn_d  = rn_q;
    if (cfg_we_i) begin
      case (skad_cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:  thr_d = cfg_wdata_i[THR_W-1:0];
        CFG_PROC_NOISE: qn_d  = cfg_wdata_i[NOISE_W-1:0];
        CFG_MEAS_NOISE: rn_d  = cfg_wdata_i[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      qn_q  <= QNOISE_RESET;
      rn_q  <= RNOISE_RESET;
    end else begin
      thr_q <= thr_d;
      qn_q  <= qn_d;
      rn_q  <= rn_d;
    end
  end

  assign cfg_o.threshold  = thr_q;
  assign cfg_o.proc_noise = qn_q;
  assign cfg_o.meas_noise = rn_q;

endmodule

// ===== rtl/skad_gain_unit.sv =====
// Serial gain unit: restoring division of the predicted variance by the innovation
// variance, one quotient bit per cycle, feeding two shift-add products with each bit.
// Depends on skad_pkg for widths, state and mode types and sat_add.
module skad_gain_unit
  import skad_pkg::*;
#(
  parameter int unsigned GainFracBits = GAIN_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [VAR_W-1:0]                num_i,
  input  logic [NOISE_W-1:0]              meas_noise_i,
  input  logic [MAG_W-1:0]                mag_i,
  output skad_gain_stat_t                 stat_o,
  output logic [GainFracBits+MAG_W-1:0]   acc_m_o,
  output logic [GainFracBits+VAR_W-1:0]   acc_p_o
);

  localparam int unsigned CntW   = $clog2(GainFracBits + 1);
  localparam int unsigned AccMW  = GainFracBits + MAG_W;
  localparam int unsigned AccPW  = GainFracBits + VAR_W;

  skad_gain_state_e  gstate_q, gstate_d;
  skad_gain_mode_e   mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [VAR_W-1:0]  num_q, num_d;
  logic [VAR_W-1:0]  den_q, den_d;
  logic [VAR_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [AccMW-1:0]  acc_m_q, acc_m_d;
  logic [AccPW-1:0]  acc_p_q, acc_p_d;

  logic [VAR_W:0]    rem_sh;
  logic [VAR_W:0]    rem_diff;
  logic              qbit;

  // One restoring step; the special cases force every quotient bit.
  always_comb begin
    rem_sh   = {rem_q, 1'b0};
    rem_diff = rem_sh - {1'b0, den_q};
    case (mode_q)
      GM_DIV:  qbit = (rem_sh >= {1'b0, den_q});
      GM_FULL: qbit = 1'b1;
      GM_ZERO: qbit = 1'b0;
      default: qbit = 1'b0;
    endcase
  end

  // Sequencing of the division and the two accumulations.
  always_comb begin
    gstate_d = gstate_q;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    mag_d    = mag_q;
    acc_m_d  = acc_m_q;
    acc_p_d  = acc_p_q;
    case (gstate_q)
      G_IDLE: begin
        if (start_i) begin
          num_d    = num_i;
          mag_d    = mag_i;
          den_d    = sat_add(num_i, meas_noise_i);
          gstate_d = G_DEN;
        end
      end
      G_DEN: begin
        if (den_q == '0) begin
          mode_d = GM_ZERO;
        end else if (num_q >= den_q) begin
          mode_d = GM_FULL;
        end else begin
          mode_d = GM_DIV;
        end
        rem_d    = num_q;
        cnt_d    = CntW'(GainFracBits);
        acc_m_d  = '0;
        acc_p_d  = '0;
        gstate_d = G_RUN;
      end
      G_RUN: begin
        if (qbit && (mode_q == GM_DIV)) begin
          rem_d = rem_diff[VAR_W-1:0];
        end else begin
          rem_d = rem_sh[VAR_W-1:0];
        end
        acc_m_d = {acc_m_q[AccMW-2:0], 1'b0} + (qbit ? AccMW'(mag_q) : '0);
        acc_p_d = {acc_p_q[AccPW-2:0], 1'b0} + (qbit ? AccPW'(num_q) : '0);
        cnt_d   = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          done_d   = 1'b1;
          gstate_d = G_IDLE;
        end
      end
      default: gstate_d = G_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gstate_q <= G_IDLE;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      mode_q   <= GM_ZERO;
    end else begin
      gstate_q <= gstate_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      mode_q   <= mode_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    mag_q   <= mag_d;
    acc_m_q <= acc_m_d;
    acc_p_q <= acc_p_d;
  end

  assign stat_o.busy = (gstate_q != G_IDLE);
  assign stat_o.done = done_q;
  assign acc_m_o     = acc_m_q;
  assign acc_p_o     = acc_p_q;

endmodule

// ===== rtl/scalar_kalman_anomaly_detector.sv =====
// Scalar Kalman anomaly detector top level: sequencer, filter state and result register.
// Depends on skad_pkg, skad_cfg_regs and skad_gain_unit.
//
// Each request carries one Q1.14 sample of a series. The block compares it with the
// current estimate, runs one random-walk Kalman step and, when the absolute deviation
// exceeds the threshold, delivers one anomaly result. The block accepts no new request
// until the update of the last one is done, and that time is set by the serial gain
// unit, which produces one quotient bit per cycle and folds it into both update
// products. A finished result waits in the output register, so the next request is
// accepted while it is still stalled; only an item that raises another anomaly holds
// in its update until that register is free. The configuration registers must be
// written only while the block is idle; the block itself does not enforce this.
module scalar_kalman_anomaly_detector
  import skad_pkg::*;
#(
  parameter int unsigned GainFracBits = GAIN_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  // Sample requests
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     series_start_i,
  input  logic signed [SAMPLE_W-1:0] ndvi_sample_i,
  input  logic [TIME_W-1:0]        sample_time_i,
  input  logic [TAG_W-1:0]         series_tag_i,
  // Anomaly results
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [TAG_W-1:0]         anomaly_tag_o,
  output logic [TIME_W-1:0]        anomaly_time_o,
  output logic signed [SAMPLE_W-1:0] observed_value_o,
  output logic signed [SAMPLE_W-1:0] expected_value_o,
  output logic signed [DEV_W-1:0]  deviation_value_o
);

  localparam int unsigned AccMW = GainFracBits + MAG_W;
  localparam int unsigned AccPW = GainFracBits + VAR_W;

  skad_cfg_t         cfg;
  skad_gain_stat_t   gain_stat;
  logic [AccMW-1:0]  acc_m;
  logic [AccPW-1:0]  acc_p;
  logic              gain_start;

  skad_state_e       state_q, state_d;
  logic signed [SAMPLE_W-1:0] est_q, est_d;
  logic [VAR_W-1:0]  var_q, var_d;

  logic signed [SAMPLE_W-1:0] z_q, z_d;
  logic signed [SAMPLE_W-1:0] exp_q, exp_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [VAR_W-1:0]  pvar_q, pvar_d;
  logic [VAR_W-1:0]  ppred_q, ppred_d;
  logic signed [DEV_W-1:0] dev_q, dev_d;
  logic [MAG_W-1:0]  mag_q, mag_d;

  logic              out_valid_q, out_valid_d;
  logic [TAG_W-1:0]  o_tag_q, o_tag_d;
  logic [TIME_W-1:0] o_time_q, o_time_d;
  logic signed [SAMPLE_W-1:0] o_obs_q, o_obs_d;
  logic signed [SAMPLE_W-1:0] o_exp_q, o_exp_d;
  logic signed [DEV_W-1:0] o_dev_q, o_dev_d;

  logic              in_accept;
  logic              anomaly;
  logic              out_load;
  logic [AccMW-1:0]  corr_sum;
  logic [MAG_W-1:0]  corr;
  logic signed [DEV_W:0] est_wide;
  logic [AccPW-1:0]  var_wide;

  skad_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  skad_gain_unit #(
    .GainFracBits (GainFracBits)
  ) u_gain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (gain_start),
    .num_i        (ppred_q),
    .meas_noise_i (cfg.meas_noise),
    .mag_i        (mag_q),
    .stat_o       (gain_stat),
    .acc_m_o      (acc_m),
    .acc_p_o      (acc_p)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign gain_start = (state_q == ST_START);

  // Update arithmetic: round both products to nearest at the gain scale.
  always_comb begin
    corr_sum = acc_m + (AccMW'(1) << (GainFracBits - 1));
    corr     = corr_sum[AccMW-1:GainFracBits];
    if (dev_q < 0) begin
      est_wide = (DEV_W+1)'(exp_q) - $signed({1'b0, corr});
    end else begin
      est_wide = (DEV_W+1)'(exp_q) + $signed({1'b0, corr});
    end
    // Ppred * (1 - K), rounded, written as Ppred * 2^G + half - K * Ppred.
    var_wide = {ppred_q, 1'b1, {(GainFracBits-1){1'b0}}} - acc_p;
    anomaly  = (mag_q > MAG_W'(cfg.threshold));
  end

  // Sequencer: next state, filter state and result register.
  always_comb begin
    state_d     = state_q;
    est_d       = est_q;
    var_d       = var_q;
    z_d         = z_q;
    exp_d       = exp_q;
    time_d      = time_q;
    tag_d       = tag_q;
    pvar_d      = pvar_q;
    ppred_d     = ppred_q;
    dev_d       = dev_q;
    mag_d       = mag_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          z_d    = ndvi_sample_i;
          time_d = sample_time_i;
          tag_d  = series_tag_i;
          // A series start reloads the estimate and the variance first.
          exp_d  = series_start_i ? ndvi_sample_i : est_q;
          pvar_d = series_start_i ? VAR_ONE : var_q;
          state_d = ST_PRED;
        end
      end
      ST_PRED: begin
        dev_d   = DEV_W'(z_q) - DEV_W'(exp_q);
        mag_d   = (dev_d < 0) ? MAG_W'(-dev_d) : MAG_W'(dev_d);
        ppred_d = sat_add(pvar_q, cfg.proc_noise);
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (gain_stat.done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // Hold here only if a result is due and the previous one is still stalled.
        if (!(anomaly && out_valid_q && out_stall_i)) begin
          est_d    = est_wide[SAMPLE_W-1:0];
          var_d    = var_wide[AccPW-1:GainFracBits];
          out_load = anomaly;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register.
  always_comb begin
    o_tag_d  = o_tag_q;
    o_time_d = o_time_q;
    o_obs_d  = o_obs_q;
    o_exp_d  = o_exp_q;
    o_dev_d  = o_dev_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      o_tag_d     = tag_q;
      o_time_d    = time_q;
      o_obs_d     = z_q;
      o_exp_d     = exp_q;
      o_dev_d     = dev_q;
      out_valid_d = 1'b1;
    end
  end

  // Control state and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      est_q       <= '0;
      var_q       <= VAR_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      est_q       <= est_d;
      var_q       <= var_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-item and result payload.
  always_ff @(posedge clk_i) begin
    z_q      <= z_d;
    exp_q    <= exp_d;
    time_q   <= time_d;
    tag_q    <= tag_d;
    pvar_q   <= pvar_d;
    ppred_q  <= ppred_d;
    dev_q    <= dev_d;
    mag_q    <= mag_d;
    o_tag_q  <= o_tag_d;
    o_time_q <= o_time_d;
    o_obs_q  <= o_obs_d;
    o_exp_q  <= o_exp_d;
    o_dev_q  <= o_dev_d;
  end

  assign out_valid_o       = out_valid_q;
  assign anomaly_tag_o     = o_tag_q;
  assign anomaly_time_o    = o_time_q;
  assign observed_value_o  = o_obs_q;
  assign expected_value_o  = o_exp_q;
  assign deviation_value_o = o_dev_q;

  // The gain unit only works while the sequencer waits for it.
  a_gain_busy_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_stat.busy |-> (state_q == ST_WAIT))
    else $error("gain unit busy outside the wait state");

  a_gain_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_stat.done |-> (state_q == ST_WAIT))
    else $error("gain result arrived outside the wait state");

  // An accepted request blocks further requests until its update is done.
  a_accept_then_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // With the result register free the update never holds.
  a_update_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && !out_valid_q |=> (state_q == ST_IDLE))
    else $error("update held although the result register was free");

endmodule
